### hdl/adli_pkg.sv
// ----------------------------------------------------------------------------
// adli_pkg
// Shared types and constants of the declipping interpolator.
// ----------------------------------------------------------------------------
package adli_pkg;

    localparam int MAX_RUN = 32;
    localparam int SAMPLE_W = 16;
    localparam int SAT_MAX = 32767;
    localparam int CLIP_HIGH_W = 15;
    localparam int RUN_AW = $clog2(MAX_RUN);
    localparam int LEN_W = $clog2(MAX_RUN + 1);
    // node positions and their differences stay within +-(MAX_RUN + 4)
    localparam int FAC_W = LEN_W + 3;
    localparam int NUM_W = 32;
    localparam int PROD_W = SAMPLE_W + NUM_W;
    localparam int SUM_W = PROD_W + 3;
    localparam int DIV_BITS = 2;
    localparam int DIV_STEPS = PROD_W / DIV_BITS;
    localparam int DIV_CW = $clog2(DIV_STEPS + 1);
    localparam int NODES = 5;
    localparam int NODE_W = $clog2(NODES);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LOW = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       restored;
        logic                       final_out;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] k;
        logic [LEN_W-1:0] len;
    } interp_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] value;
    } interp_rsp_t;

endpackage

### hdl/adli_ram.sv
// ----------------------------------------------------------------------------
// adli_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module adli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/adli_div.sv
// ----------------------------------------------------------------------------
// adli_div
// Iterative signed divider, quotient truncated toward zero, two bits a cycle.
// ----------------------------------------------------------------------------
module adli_div import adli_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [PROD_W-1:0] dividend,
    input  logic signed [NUM_W-1:0]  divisor,
    output logic                     done,
    output logic signed [PROD_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [NUM_W:0]    rem_reg;
    logic [PROD_W-1:0] q_reg;
    logic [NUM_W-1:0]  dsr_reg;
    logic              neg_reg;

    logic [NUM_W:0]    rem_next;
    logic [PROD_W-1:0] q_next;
    logic [PROD_W-1:0] dvd_mag;
    logic [NUM_W-1:0]  dsr_mag;

    assign dvd_mag = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
    assign dsr_mag = divisor[NUM_W-1] ? NUM_W'(-divisor) : NUM_W'(divisor);

    always_comb
    begin
        rem_next = rem_reg;
        q_next = q_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            rem_next = {rem_next[NUM_W-1:0], q_next[PROD_W-1]};
            q_next = {q_next[PROD_W-2:0], 1'b0};
            if (rem_next >= {1'b0, dsr_reg})
            begin
                rem_next = rem_next - {1'b0, dsr_reg};
                q_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= DIV_CW'(DIV_STEPS);
                rem_reg <= '0;
                q_reg <= dvd_mag;
                dsr_reg <= dsr_mag;
                neg_reg <= dividend[PROD_W-1] ^ divisor[NUM_W-1];
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                q_reg <= q_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

### hdl/adli_interp.sv
// ----------------------------------------------------------------------------
// adli_interp
// Lagrange term engine: builds the five basis terms of one run sample in turn.
// ----------------------------------------------------------------------------
module adli_interp import adli_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  interp_req_t                req,
    input  logic signed [SAMPLE_W-1:0] nodes [NODES],
    output interp_rsp_t                rsp
);

    typedef enum logic [2:0] {
        I_IDLE,
        I_INIT,
        I_MUL,
        I_PROD,
        I_DIV,
        I_WAIT,
        I_SAT
    } istate_t;

    istate_t                    state_reg;
    logic [NODE_W-1:0]          a_reg;
    logic [NODE_W-1:0]          b_reg;
    logic [LEN_W-1:0]           k_reg;
    logic [LEN_W-1:0]           len_reg;
    logic signed [NUM_W-1:0]    num_reg;
    logic signed [NUM_W-1:0]    den_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic                       done_reg;
    logic signed [SAMPLE_W-1:0] value_reg;

    logic signed [FAC_W-1:0]       fk;
    logic signed [FAC_W-1:0]       fd;
    logic signed [NUM_W+FAC_W-1:0] num_ext;
    logic signed [NUM_W+FAC_W-1:0] den_ext;
    logic                          div_done;
    logic signed [PROD_W-1:0]      quot;

    function automatic logic signed [FAC_W-1:0] node_pos(
        input logic [NODE_W-1:0] idx,
        input logic [LEN_W-1:0]  len
    );
        logic signed [FAC_W-1:0] p;
        unique case (idx)
            NODE_W'(0): p = FAC_W'(-3);
            NODE_W'(1): p = FAC_W'(-2);
            NODE_W'(2): p = FAC_W'(-1);
            NODE_W'(3): p = $signed({3'b000, len});
            default:    p = $signed({3'b000, len}) + FAC_W'(1);
        endcase
        return p;
    endfunction

    assign fk = $signed({3'b000, k_reg}) - node_pos(b_reg, len_reg);
    assign fd = node_pos(a_reg, len_reg) - node_pos(b_reg, len_reg);
    assign num_ext = num_reg * fk;
    assign den_ext = den_reg * fd;

    adli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == I_DIV),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= I_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                I_IDLE:
                begin
                    if (req.start)
                    begin
                        k_reg <= req.k;
                        len_reg <= req.len;
                        a_reg <= '0;
                        sum_reg <= '0;
                        state_reg <= I_INIT;
                    end
                end
                I_INIT:
                begin
                    num_reg <= NUM_W'(1);
                    den_reg <= NUM_W'(1);
                    b_reg <= '0;
                    state_reg <= I_MUL;
                end
                I_MUL:
                begin
                    if (b_reg != a_reg)
                    begin
                        num_reg <= NUM_W'(num_ext);
                        den_reg <= NUM_W'(den_ext);
                    end
                    if (b_reg == NODE_W'(NODES - 1))
                    begin
                        state_reg <= I_PROD;
                    end
                    else
                    begin
                        b_reg <= b_reg + 1'b1;
                    end
                end
                I_PROD:
                begin
                    prod_reg <= nodes[a_reg] * num_reg;
                    state_reg <= I_DIV;
                end
                I_DIV:
                begin
                    state_reg <= I_WAIT;
                end
                I_WAIT:
                begin
                    if (div_done)
                    begin
                        sum_reg <= sum_reg + SUM_W'(quot);
                        if (a_reg == NODE_W'(NODES - 1))
                        begin
                            state_reg <= I_SAT;
                        end
                        else
                        begin
                            a_reg <= a_reg + 1'b1;
                            state_reg <= I_INIT;
                        end
                    end
                end
                I_SAT:
                begin
                    if (sum_reg > $signed(SUM_W'(SAT_MAX)))
                    begin
                        value_reg <= SAMPLE_W'(SAT_MAX);
                    end
                    else if (sum_reg < $signed(SUM_W'(-SAT_MAX - 1)))
                    begin
                        value_reg <= SAMPLE_W'(-SAT_MAX - 1);
                    end
                    else
                    begin
                        value_reg <= sum_reg[SAMPLE_W-1:0];
                    end
                    done_reg <= 1'b1;
                    state_reg <= I_IDLE;
                end
                default:
                begin
                    state_reg <= I_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.value = value_reg;

endmodule

### hdl/audio_declip_lagrange_interp.sv
// ----------------------------------------------------------------------------
// audio_declip_lagrange_interp
// Holds runs of clipped samples and rebuilds them by Lagrange interpolation.
// ----------------------------------------------------------------------------
// an unclipped sample is put out through the result register; a new beat waits for ST_IDLE
// a held run of length L is released when its second following sample arrives,
// each sample rebuilt from five basis terms, built in turn through
// shared multipliers and a two-bit-a-cycle divider
// raw flushes read the run memory one entry at a time, in ST_FLUSH_RD then ST_FLUSH_EM
// reset restores the clip levels and empties history; memory needs no clearing
module audio_declip_lagrange_interp import adli_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  in_item_t             sample,
    output logic                 result_valid,
    input  logic                 result_ready,
    output out_item_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FRESH,
        ST_EMIT_S,
        ST_TAIL,
        ST_FLUSH_RD,
        ST_FLUSH_EM,
        ST_INTERP_GO,
        ST_INTERP_WAIT,
        ST_INTERP_EM,
        ST_EMIT_AFTER,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COLLECT,
        PH_HOLD,
        PH_PASS
    } phase_t;

    typedef enum logic [1:0] {
        NX_EMIT_S,
        NX_AFTER,
        NX_DONE,
        NX_FRESH
    } then_t;

    state_t                     state_reg;
    phase_t                     phase_reg;
    then_t                      then_reg;
    logic [CLIP_HIGH_W-1:0]     clip_high_reg;
    logic signed [SAMPLE_W-1:0] clip_low_reg;
    logic signed [SAMPLE_W-1:0] s_reg;
    logic                       eos_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [LEN_W-1:0]           k_reg;
    logic signed [SAMPLE_W-1:0] hist_reg [3];
    logic [1:0]                 hist_cnt_reg;
    logic signed [SAMPLE_W-1:0] after_reg;
    logic signed [SAMPLE_W-1:0] node_reg [NODES];
    logic signed [SAMPLE_W-1:0] ival_reg;
    logic                       result_valid_reg;
    out_item_t                  result_reg;

    logic                       clipped;
    logic                       slot_free;
    logic                       emit_req;
    logic                       emit_fire;
    out_item_t                  emit_item;
    logic                       ram_we;
    logic [RUN_AW-1:0]          ram_waddr;
    logic                       ram_re;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic                       k_last;
    interp_req_t                ireq;
    interp_rsp_t                irsp;

    assign clipped = (s_reg == $signed({1'b0, clip_high_reg})) || (s_reg == clip_low_reg);
    assign slot_free = !result_valid_reg || result_ready;
    assign k_last = (k_reg + 1'b1) == len_reg;

    // which beat, if any, the current state wants to put out
    always_comb
    begin
        emit_req = 1'b0;
        emit_item.sample_out = s_reg;
        emit_item.restored = 1'b0;
        emit_item.final_out = eos_reg;
        unique case (state_reg)
            ST_FRESH:
            begin
                emit_req = !clipped || (hist_cnt_reg != 2'd3);
            end
            ST_EMIT_S:
            begin
                emit_req = 1'b1;
            end
            ST_FLUSH_EM:
            begin
                emit_req = 1'b1;
                emit_item.sample_out = $signed(ram_rdata);
                emit_item.final_out = eos_reg && (then_reg == NX_DONE) && k_last;
            end
            ST_INTERP_EM:
            begin
                emit_req = 1'b1;
                emit_item.sample_out = ival_reg;
                emit_item.restored = 1'b1;
                emit_item.final_out = 1'b0;
            end
            ST_EMIT_AFTER:
            begin
                emit_req = 1'b1;
                emit_item.sample_out = after_reg;
                emit_item.final_out = (then_reg == NX_DONE);
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    assign emit_fire = emit_req && slot_free;

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = len_reg[RUN_AW-1:0];
        if (state_reg == ST_DISPATCH && phase_reg == PH_COLLECT && clipped
            && len_reg != LEN_W'(MAX_RUN))
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == ST_FRESH && clipped && hist_cnt_reg == 2'd3)
        begin
            ram_we = 1'b1;
            ram_waddr = '0;
        end
    end

    assign ram_re = (state_reg == ST_FLUSH_RD);

    adli_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_RUN)
    ) u_run_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_reg),
        .re    (ram_re),
        .raddr (k_reg[RUN_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ireq.start = (state_reg == ST_INTERP_GO);
    assign ireq.k = k_reg;
    assign ireq.len = len_reg;

    adli_interp u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ireq),
        .nodes (node_reg),
        .rsp   (irsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            then_reg <= NX_DONE;
            clip_high_reg <= CLIP_HIGH_W'(SAT_MAX);
            clip_low_reg <= SAMPLE_W'(-SAT_MAX);
            len_reg <= '0;
            k_reg <= '0;
            hist_reg <= '{default: '0};
            hist_cnt_reg <= '0;
            after_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_CLIP_HIGH: clip_high_reg <= cfg_data[CLIP_HIGH_W-1:0];
                    REG_CLIP_LOW:  clip_low_reg <= $signed(cfg_data);
                    default:       clip_low_reg <= clip_low_reg;
                endcase
            end

            if (emit_fire)
            begin
                result_valid_reg <= 1'b1;
                result_reg <= emit_item;
                hist_reg[0] <= hist_reg[1];
                hist_reg[1] <= hist_reg[2];
                hist_reg[2] <= emit_item.sample_out;
                if (hist_cnt_reg != 2'd3)
                begin
                    hist_cnt_reg <= hist_cnt_reg + 1'b1;
                end
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid)
                    begin
                        s_reg <= sample.sample_in;
                        eos_reg <= sample.end_of_stream;
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH:
                begin
                    unique case (phase_reg)
                        PH_COLLECT:
                        begin
                            if (!clipped)
                            begin
                                after_reg <= s_reg;
                                phase_reg <= PH_HOLD;
                                state_reg <= ST_TAIL;
                            end
                            else if (len_reg == LEN_W'(MAX_RUN))
                            begin
                                // run overflows the buffer: release it raw
                                phase_reg <= PH_PASS;
                                k_reg <= '0;
                                then_reg <= NX_EMIT_S;
                                state_reg <= ST_FLUSH_RD;
                            end
                            else
                            begin
                                len_reg <= len_reg + 1'b1;
                                state_reg <= ST_TAIL;
                            end
                        end
                        PH_HOLD:
                        begin
                            node_reg[0] <= hist_reg[0];
                            node_reg[1] <= hist_reg[1];
                            node_reg[2] <= hist_reg[2];
                            node_reg[3] <= after_reg;
                            node_reg[4] <= s_reg;
                            k_reg <= '0;
                            state_reg <= ST_INTERP_GO;
                        end
                        PH_PASS:
                        begin
                            state_reg <= ST_EMIT_S;
                        end
                        default:
                        begin
                            state_reg <= ST_FRESH;
                        end
                    endcase
                end
                ST_FRESH:
                begin
                    if (!clipped)
                    begin
                        if (emit_fire)
                        begin
                            state_reg <= ST_TAIL;
                        end
                    end
                    else if (hist_cnt_reg != 2'd3)
                    begin
                        // too little history: pass this run through raw
                        if (emit_fire)
                        begin
                            phase_reg <= PH_PASS;
                            state_reg <= ST_TAIL;
                        end
                    end
                    else
                    begin
                        len_reg <= LEN_W'(1);
                        phase_reg <= PH_COLLECT;
                        state_reg <= ST_TAIL;
                    end
                end
                ST_EMIT_S:
                begin
                    if (emit_fire)
                    begin
                        if (!clipped)
                        begin
                            phase_reg <= PH_IDLE;
                        end
                        state_reg <= ST_TAIL;
                    end
                end
                ST_TAIL:
                begin
                    if (!eos_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (phase_reg == PH_COLLECT)
                    begin
                        k_reg <= '0;
                        then_reg <= NX_DONE;
                        state_reg <= ST_FLUSH_RD;
                    end
                    else if (phase_reg == PH_HOLD)
                    begin
                        k_reg <= '0;
                        then_reg <= NX_AFTER;
                        state_reg <= ST_FLUSH_RD;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_FLUSH_RD:
                begin
                    state_reg <= ST_FLUSH_EM;
                end
                ST_FLUSH_EM:
                begin
                    if (emit_fire)
                    begin
                        if (k_last)
                        begin
                            len_reg <= '0;
                            k_reg <= '0;
                            unique case (then_reg)
                                NX_EMIT_S:
                                begin
                                    state_reg <= ST_EMIT_S;
                                end
                                NX_AFTER:
                                begin
                                    then_reg <= NX_DONE;
                                    state_reg <= ST_EMIT_AFTER;
                                end
                                default:
                                begin
                                    state_reg <= ST_DONE;
                                end
                            endcase
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            state_reg <= ST_FLUSH_RD;
                        end
                    end
                end
                ST_INTERP_GO:
                begin
                    state_reg <= ST_INTERP_WAIT;
                end
                ST_INTERP_WAIT:
                begin
                    if (irsp.done)
                    begin
                        ival_reg <= irsp.value;
                        state_reg <= ST_INTERP_EM;
                    end
                end
                ST_INTERP_EM:
                begin
                    if (emit_fire)
                    begin
                        if (k_last)
                        begin
                            len_reg <= '0;
                            k_reg <= '0;
                            then_reg <= NX_FRESH;
                            state_reg <= ST_EMIT_AFTER;
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            state_reg <= ST_INTERP_GO;
                        end
                    end
                end
                ST_EMIT_AFTER:
                begin
                    if (emit_fire)
                    begin
                        if (then_reg == NX_DONE)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            // second node is then taken as a fresh sample
                            phase_reg <= PH_IDLE;
                            state_reg <= ST_FRESH;
                        end
                    end
                end
                ST_DONE:
                begin
                    len_reg <= '0;
                    k_reg <= '0;
                    hist_reg <= '{default: '0};
                    hist_cnt_reg <= '0;
                    after_reg <= '0;
                    phase_reg <= PH_IDLE;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sample_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule

### verif/audio_declip_lagrange_interp_tb.sv
// ----------------------------------------------------------------------------
// audio_declip_lagrange_interp_tb
// Self-checking bench for the declipping interpolator: directed and random
// sample streams with clipped runs, clip level changes between streams, and
// random stalls on both channels. Every result beat is checked against a
// predictor of the run hold and Lagrange repair.
// ----------------------------------------------------------------------------
module audio_declip_lagrange_interp_tb;
    import adli_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 100;

    typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_AFTER, PH_RAW} phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    in_item_t sample = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    out_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CLIP_HIGH;
    logic [SAMPLE_W-1:0] cfg_data = '0;

    // predictor state
    logic [CLIP_HIGH_W-1:0] clip_hi;
    logic signed [SAMPLE_W-1:0] clip_lo;
    logic signed [SAMPLE_W-1:0] held_run [MAX_RUN];
    int run_len;
    logic signed [SAMPLE_W-1:0] prev_out [3];
    int prev_cnt;
    logic signed [SAMPLE_W-1:0] after_node;
    phase_t phase;

    out_item_t pending_q [$];
    int errors = 0;
    int sent = 0;
    int quiet = 0;
    bit hold_rx = 1'b0;
    bit idle_on = 1'b1;

    always #6 clk = ~clk;

    audio_declip_lagrange_interp u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample      (sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    function automatic bit is_clip(logic signed [SAMPLE_W-1:0] s);
        return (int'(s) == int'(clip_hi)) || (s == clip_lo);
    endfunction

    function automatic void put(logic signed [SAMPLE_W-1:0] v, bit rest);
        out_item_t o;
        o.sample_out = v;
        o.restored = rest;
        o.final_out = 1'b0;
        pending_q.push_back(o);
        prev_out[0] = prev_out[1];
        prev_out[1] = prev_out[2];
        prev_out[2] = v;
        if (prev_cnt < 3) prev_cnt++;
    endfunction

    function automatic void flush_held();
        for (int k = 0; k < run_len; k++) put(held_run[k], 1'b0);
        run_len = 0;
    endfunction

    function automatic void repair_run(logic signed [SAMPLE_W-1:0] second);
        longint xs [5];
        longint vs [5];
        logic signed [SAMPLE_W-1:0] vals [MAX_RUN];
        longint acc, num, den;
        xs = '{-3, -2, -1, run_len, run_len + 1};
        vs = '{prev_out[0], prev_out[1], prev_out[2], after_node, second};
        for (int k = 0; k < run_len; k++)
        begin
            acc = 0;
            for (int a = 0; a < 5; a++)
            begin
                num = 1;
                den = 1;
                for (int b = 0; b < 5; b++)
                begin
                    if (b != a)
                    begin
                        num *= longint'(k) - xs[b];
                        den *= xs[a] - xs[b];
                    end
                end
                acc += vs[a] * num / den;
            end
            if (acc > 32767) acc = 32767;
            if (acc < -32768) acc = -32768;
            vals[k] = acc[SAMPLE_W-1:0];
        end
        for (int k = 0; k < run_len; k++) put(vals[k], 1'b1);
        run_len = 0;
    endfunction

    function automatic void take_fresh(logic signed [SAMPLE_W-1:0] s);
        if (!is_clip(s))
            put(s, 1'b0);
        else if (prev_cnt < 3)
        begin
            put(s, 1'b0);
            phase = PH_RAW;
        end
        else
        begin
            held_run[0] = s;
            run_len = 1;
            phase = PH_RUN;
        end
    endfunction

    function automatic void clear_stream();
        run_len = 0;
        prev_out = '{default: '0};
        prev_cnt = 0;
        after_node = '0;
        phase = PH_IDLE;
    endfunction

    function automatic void predict_declip(in_item_t it);
        int n0;
        bit c;
        n0 = pending_q.size();
        c = is_clip(it.sample_in);
        case (phase)
            PH_RUN:
                if (c)
                begin
                    if (run_len >= MAX_RUN)
                    begin
                        flush_held();
                        put(it.sample_in, 1'b0);
                        phase = PH_RAW;
                    end
                    else
                    begin
                        held_run[run_len] = it.sample_in;
                        run_len++;
                    end
                end
                else
                begin
                    after_node = it.sample_in;
                    phase = PH_AFTER;
                end
            PH_AFTER:
            begin
                repair_run(it.sample_in);
                put(after_node, 1'b0);
                phase = PH_IDLE;
                take_fresh(it.sample_in);
            end
            PH_RAW:
            begin
                put(it.sample_in, 1'b0);
                if (!c) phase = PH_IDLE;
            end
            default: take_fresh(it.sample_in);
        endcase
        if (it.end_of_stream)
        begin
            if (phase == PH_RUN)
                flush_held();
            else if (phase == PH_AFTER)
            begin
                flush_held();
                put(after_node, 1'b0);
            end
            if (pending_q.size() > n0) pending_q[pending_q.size()-1].final_out = 1'b1;
            clear_stream();
        end
    endfunction

    // input beats feed the predictor before output beats are checked
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (sample_valid && sample_ready) predict_declip(sample);
            if (result_valid && result_ready)
            begin
                if (pending_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat, actual %p", $realtime, result);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (result.sample_out !== want.sample_out)
                    begin
                        errors++;
                        $display("%0t: sample_out expected %0d actual %0d", $realtime,
                                 want.sample_out, result.sample_out);
                    end
                    if (result.restored !== want.restored)
                    begin
                        errors++;
                        $display("%0t: restored expected %0b actual %0b", $realtime,
                                 want.restored, result.restored);
                    end
                    if (result.final_out !== want.final_out)
                    begin
                        errors++;
                        $display("%0t: final_out expected %0b actual %0b", $realtime,
                                 want.final_out, result.final_out);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver with random stalls and an occasional long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = idle_on ? $urandom_range(0, 8) : 0;
            if (hold_rx)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_rx = 1'b0;
            end
            else if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(logic signed [SAMPLE_W-1:0] s, bit eos);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample <= '{s, eos};
        sample_valid <= 1'b1;
        do @(posedge clk); while (!sample_ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (64) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_CLIP_HIGH)
            clip_hi = val[CLIP_HIGH_W-1:0];
        else
            clip_lo = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] clip_val();
        return $urandom_range(0, 1) ? {1'b0, clip_hi} : clip_lo;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] plain_val();
        logic signed [SAMPLE_W-1:0] v;
        do
        begin
            case ($urandom_range(0, 3))
                0: v = 16'($urandom);
                1: v = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
                2: v = $urandom_range(0, 1) ? 16'sh7ffe : -16'sh7ffe;
                default: v = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
            endcase
        end
        while (is_clip(v));
        return v;
    endfunction

    // one stream: a lead-in, then clipped runs, most with their two following nodes, at times a random tail
    task automatic play_stream(int runs);
        logic signed [SAMPLE_W-1:0] seq [$];
        int len;
        repeat ($urandom_range(0, 5)) seq.push_back(plain_val());
        for (int r = 0; r < runs; r++)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 6);
            repeat (len) seq.push_back(clip_val());
            if ($urandom_range(0, 9) == 0) break;
            seq.push_back(plain_val());
            seq.push_back($urandom_range(0, 5) == 0 ? clip_val() : plain_val());
            repeat ($urandom_range(0, 3)) seq.push_back(plain_val());
        end
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(3, 12))
                seq.push_back($urandom_range(0, 2) == 0 ? clip_val() : 16'($urandom));
        if (seq.size() == 0) seq.push_back(plain_val());
        foreach (seq[i]) send_sample(seq[i], i == seq.size() - 1);
    endtask

    task automatic test_extremes();
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32767, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd32766, 1'b1);
        send_sample(16'sd32767, 1'b1);
        drain();
    endtask

    task automatic test_runs();
        // repaired run with plain second node
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd20000, 1'b0);
        send_sample(16'sd30000, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd29000, 1'b0);
        send_sample(16'sd25000, 1'b0);
        // second node clipped, starts a fresh run which the stream end cuts
        send_sample(-16'sd32767, 1'b0);
        send_sample(-16'sd20000, 1'b0);
        send_sample(-16'sd32767, 1'b0);
        send_sample(-16'sd32767, 1'b1);
        // run cut while its first following sample is held
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd6, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd8, 1'b1);
        drain();
        // run at stream start goes through raw
        send_sample(-16'sd32767, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd1, 1'b1);
        drain();
        // overlong run
        repeat (3) send_sample(16'sd1000, 1'b0);
        repeat (MAX_RUN + 2) send_sample(16'sd32767, 1'b0);
        send_sample(16'sd10, 1'b0);
        send_sample(16'sd11, 1'b1);
        drain();
    endtask

    task automatic test_clip_levels();
        write_reg(REG_CLIP_HIGH, 16'h0000);
        write_reg(REG_CLIP_LOW, 16'h0000);
        play_stream(2);
        drain();
        write_reg(REG_CLIP_HIGH, 16'hffff);
        write_reg(REG_CLIP_LOW, 16'h8000);
        play_stream(2);
        drain();
        write_reg(REG_CLIP_HIGH, 16'd12000);
        write_reg(REG_CLIP_LOW, -16'sd12000);
        play_stream(2);
        drain();
        write_reg(REG_CLIP_HIGH, 16'h7fff);
        write_reg(REG_CLIP_LOW, 16'h8001);
    endtask

    task automatic test_backpressure();
        hold_rx = 1'b1;
        idle_on = 1'b0;
        for (int i = 0; i < 30; i++) send_sample(plain_val(), i == 29);
        idle_on = 1'b1;
        drain();
        play_stream(3);
        drain();
        play_stream(2);
        drain();
    endtask

    task automatic test_random();
        int base;
        base = sent;
        while (sent - base < RANDOM_ITEMS)
        begin
            idle_on = $urandom_range(0, 4) != 0;
            play_stream($urandom_range(1, 4));
            if ($urandom_range(0, 9) == 0)
            begin
                drain();
                write_reg($urandom_range(0, 1) ? REG_CLIP_HIGH : REG_CLIP_LOW, 16'($urandom));
            end
        end
        idle_on = 1'b1;
        drain();
    endtask

    initial
    begin
        clip_hi = 15'h7fff;
        clip_lo = -16'sd32767;
        held_run = '{default: '0};
        clear_stream();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes();
        test_runs();
        test_clip_levels();
        test_backpressure();
        test_random();
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
